// File: rtl/npcl_pkg.sv
package npcl_pkg;

  localparam int MAX_COLORS = 256;
  localparam int SLOT_LIMIT = 256;
  localparam int SLOTS      = (MAX_COLORS < SLOT_LIMIT) ? MAX_COLORS : SLOT_LIMIT;
  localparam int IDX_W      = $clog2(MAX_COLORS);
  localparam int COUNT_W    = 9;
  localparam int CMP_W      = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
  localparam int CH_W       = 8;
  localparam int COLOR_W    = 8;
  localparam int DIST_W     = 18;
  localparam int SQ_W       = 2 * CH_W;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_MAP  = 1'b1
  } mode_t;

  typedef enum logic [0:0] {
    REG_COLOR_COUNT   = 1'b0,
    REG_CHANNEL_COUNT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    mode_t               mode;
    logic [COLOR_W-1:0]  entry_index;
    logic [CH_W-1:0]     ch0;
    logic [CH_W-1:0]     ch1;
    logic [CH_W-1:0]     ch2;
    logic [COLOR_W-1:0]  best_idx;
    logic [DIST_W-1:0]   best_dist;
    logic                pend_vld;
    logic [COLOR_W-1:0]  pend_idx;
    logic [DIST_W-1:0]   pend_dist;
  } beat_t;

  typedef struct packed {
    logic               adv;
    logic [COUNT_W-1:0] eff_count;
    logic [2:0]         ch_en;
  } ctrl_t;

endpackage

// File: rtl/npcl_if.sv
interface npcl_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] entry_index;
  logic [7:0] channel_0;
  logic [7:0] channel_1;
  logic [7:0] channel_2;

  modport source (output valid, mode, entry_index, channel_0, channel_1, channel_2,
                  input ready);
  modport sink (input valid, mode, entry_index, channel_0, channel_1, channel_2,
                output ready);
endinterface

interface npcl_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  color_index;
  logic [17:0] min_distance;

  modport source (output valid, color_index, min_distance, input ready);
  modport sink (input valid, color_index, min_distance, output ready);
endinterface

// File: rtl/nearest_palette_color_lookup_core.sv
// Nearest palette color lookup. The palette sits in a systolic row of
// npcl_pkg::MAX_COLORS cells, one entry per cell, and every beat, load or map,
// walks down the row one cell per cycle while the row advances. A new beat is
// taken in every cycle while the output register is free or being emptied, so
// the block sustains one pixel per cycle; a map result passes through every
// cell register and then the output register, and loads reach their cell
// ahead of every later pixel, so results always see the palette as loaded
// up to that pixel. A held result stalls the whole row. Load beats give no
// result, and palette entries taking part in a search must be loaded first.
module nearest_palette_color_lookup_core (
  input  logic                          clk,
  input  logic                          rst_n,
  npcl_in_if.sink                       in_bus,
  npcl_out_if.source                    out_bus,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [npcl_pkg::COUNT_W-1:0]  cfg_wdata
);

  localparam int N = npcl_pkg::MAX_COLORS;

  logic [npcl_pkg::COUNT_W-1:0] color_count_r;
  logic [1:0]                   channel_count_r;
  npcl_pkg::ctrl_t              ctrl;
  logic                         vld [0:N];
  npcl_pkg::beat_t              beat [0:N];
  logic                         out_valid_r;
  logic [npcl_pkg::COLOR_W-1:0] out_idx_r;
  logic [npcl_pkg::DIST_W-1:0]  out_dist_r;
  logic                         better;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_count_r   <= npcl_pkg::COUNT_W'(256);
      channel_count_r <= 2'd3;
    end else if (cfg_we) begin
      case (npcl_pkg::reg_idx_t'(cfg_index))
        npcl_pkg::REG_COLOR_COUNT:   color_count_r   <= cfg_wdata;
        npcl_pkg::REG_CHANNEL_COUNT: channel_count_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ctrl.adv = !out_valid_r || out_bus.ready;
    if (color_count_r == '0) begin
      ctrl.eff_count = npcl_pkg::COUNT_W'(1);
    end else if (color_count_r > npcl_pkg::COUNT_W'(npcl_pkg::SLOTS)) begin
      ctrl.eff_count = npcl_pkg::COUNT_W'(npcl_pkg::SLOTS);
    end else begin
      ctrl.eff_count = color_count_r;
    end
    ctrl.ch_en[0] = channel_count_r >= 2'd1;
    ctrl.ch_en[1] = channel_count_r >= 2'd2;
    ctrl.ch_en[2] = channel_count_r == 2'd3;
  end

  assign in_bus.ready = ctrl.adv;

  always_comb begin
    vld[0]              = in_bus.valid;
    beat[0].mode        = npcl_pkg::mode_t'(in_bus.mode);
    beat[0].entry_index = in_bus.entry_index;
    beat[0].ch0         = in_bus.channel_0;
    beat[0].ch1         = in_bus.channel_1;
    beat[0].ch2         = in_bus.channel_2;
    beat[0].best_idx    = '0;
    beat[0].best_dist   = '1;
    beat[0].pend_vld    = 1'b0;
    beat[0].pend_idx    = '0;
    beat[0].pend_dist   = '0;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    npcl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .cell_idx (npcl_pkg::IDX_W'(i)),
      .in_vld   (vld[i]),
      .in_beat  (beat[i]),
      .out_vld  (vld[i+1]),
      .out_beat (beat[i+1])
    );
  end

  assign better = beat[N].pend_vld && (beat[N].pend_dist < beat[N].best_dist);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.adv) begin
      out_valid_r <= vld[N] && (beat[N].mode == npcl_pkg::MODE_MAP);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      out_idx_r  <= better ? beat[N].pend_idx : beat[N].best_idx;
      out_dist_r <= better ? beat[N].pend_dist : beat[N].best_dist;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.color_index  = out_idx_r;
  assign out_bus.min_distance = out_dist_r;

endmodule

// File: rtl/npcl_cell.sv
module npcl_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  npcl_pkg::ctrl_t             ctrl,
  input  logic [npcl_pkg::IDX_W-1:0]  cell_idx,
  input  logic                        in_vld,
  input  npcl_pkg::beat_t             in_beat,
  output logic                        out_vld,
  output npcl_pkg::beat_t             out_beat
);

  logic [npcl_pkg::CH_W-1:0]   entry0_r, entry1_r, entry2_r;
  logic                        out_vld_r;
  npcl_pkg::beat_t             out_beat_r;
  npcl_pkg::beat_t             beat_nxt;
  logic [npcl_pkg::CH_W-1:0]   d0, d1, d2;
  logic [npcl_pkg::SQ_W-1:0]   s0, s1, s2;
  logic                        better;
  logic                        hit;
  logic                        part;

  assign hit = in_vld && (in_beat.mode == npcl_pkg::MODE_LOAD) &&
               (npcl_pkg::CMP_W'(in_beat.entry_index) == npcl_pkg::CMP_W'(cell_idx));
  assign part = npcl_pkg::CMP_W'(cell_idx) < npcl_pkg::CMP_W'(ctrl.eff_count);

  always_comb begin
    d0 = (in_beat.ch0 >= entry0_r) ? in_beat.ch0 - entry0_r : entry0_r - in_beat.ch0;
    d1 = (in_beat.ch1 >= entry1_r) ? in_beat.ch1 - entry1_r : entry1_r - in_beat.ch1;
    d2 = (in_beat.ch2 >= entry2_r) ? in_beat.ch2 - entry2_r : entry2_r - in_beat.ch2;
    s0 = ctrl.ch_en[0] ? npcl_pkg::SQ_W'(d0) * npcl_pkg::SQ_W'(d0) : '0;
    s1 = ctrl.ch_en[1] ? npcl_pkg::SQ_W'(d1) * npcl_pkg::SQ_W'(d1) : '0;
    s2 = ctrl.ch_en[2] ? npcl_pkg::SQ_W'(d2) * npcl_pkg::SQ_W'(d2) : '0;
    better = in_beat.pend_vld && (in_beat.pend_dist < in_beat.best_dist);
    beat_nxt = in_beat;
    if (better) begin
      beat_nxt.best_idx  = in_beat.pend_idx;
      beat_nxt.best_dist = in_beat.pend_dist;
    end
    beat_nxt.pend_vld  = part;
    beat_nxt.pend_idx  = npcl_pkg::COLOR_W'(cell_idx);
    beat_nxt.pend_dist = npcl_pkg::DIST_W'(s0) + npcl_pkg::DIST_W'(s1) +
                         npcl_pkg::DIST_W'(s2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ctrl.adv) begin
      out_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      out_beat_r <= beat_nxt;
    end
    if (ctrl.adv && hit) begin
      entry0_r <= in_beat.ch0;
      entry1_r <= in_beat.ch1;
      entry2_r <= in_beat.ch2;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_beat = out_beat_r;

endmodule

// File: tb/tb_nearest_palette_color_lookup_core.sv
`timescale 1ns / 100ps

module tb_nearest_palette_color_lookup_core;
  import npcl_pkg::*;

  localparam int HOLD_CYCLES  = 600;
  localparam int SETTLE_CYCLES = MAX_COLORS + 8;

  class palette_scoreboard;
    typedef struct packed {
      logic [COLOR_W-1:0] idx;
      logic [DIST_W-1:0]  sq_dist;
    } lookup_t;

    logic [CH_W-1:0] pal [SLOTS][3];
    bit              written [SLOTS];
    int unsigned     count_reg;
    int unsigned     chan_reg;
    lookup_t         nearest_q[$];
    int              mismatches;
    int              loads_seen;
    int              maps_seen;
    int              results_seen;

    function new();
      count_reg = 256;
      chan_reg  = 3;
    endfunction

    function void write_reg(reg_idx_t r, logic [COUNT_W-1:0] v);
      case (r)
        REG_COLOR_COUNT:   count_reg = 32'(v);
        REG_CHANNEL_COUNT: chan_reg = 32'(v[1:0]);
        default: ;
      endcase
    endfunction

    function int unsigned active_entries();
      int unsigned n;
      n = count_reg;
      if (n == 0) n = 1;
      if (n > MAX_COLORS) n = MAX_COLORS;
      if (n > SLOT_LIMIT) n = SLOT_LIMIT;
      return n;
    endfunction

    function lookup_t nearest(logic [CH_W-1:0] c0, logic [CH_W-1:0] c1,
                              logic [CH_W-1:0] c2);
      logic [CH_W-1:0] px [3];
      int unsigned     best_d;
      int unsigned     d;
      int              diff;
      lookup_t         r;
      px[0]  = c0;
      px[1]  = c1;
      px[2]  = c2;
      best_d = 32'hFFFF_FFFF;
      r.idx  = '0;
      for (int i = 0; i < active_entries(); i++) begin
        d = 0;
        for (int k = 0; k < 3; k++) begin
          if (k < chan_reg) begin
            diff = int'(px[k]) - int'(pal[i][k]);
            d += diff * diff;
          end
        end
        if (d < best_d) begin
          best_d = d;
          r.idx  = i[COLOR_W-1:0];
        end
      end
      r.sq_dist = best_d[DIST_W-1:0];
      return r;
    endfunction

    function void note_beat(mode_t m, logic [COLOR_W-1:0] slot, logic [CH_W-1:0] c0,
                            logic [CH_W-1:0] c1, logic [CH_W-1:0] c2);
      if (m == MODE_LOAD) begin
        loads_seen++;
        if (slot < MAX_COLORS) begin
          pal[slot][0] = c0;
          pal[slot][1] = c1;
          pal[slot][2] = c2;
          written[slot] = 1'b1;
        end
      end else begin
        maps_seen++;
        nearest_q.push_back(nearest(c0, c1, c2));
      end
    endfunction

    function void check_result(logic [COLOR_W-1:0] idx, logic [DIST_W-1:0] got_dist);
      lookup_t want;
      results_seen++;
      if (nearest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result index %0d distance %0d", $time, idx, got_dist);
        return;
      end
      want = nearest_q.pop_front();
      if (want.idx !== idx || want.sq_dist !== got_dist) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result %0d: expected index %0d distance %0d, got index %0d distance %0d",
                   $time, results_seen, want.idx, want.sq_dist, idx, got_dist);
      end
    endfunction

    function int pending();
      return nearest_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [0:0]          cfg_index;
  logic [COUNT_W-1:0]  cfg_wdata;
  bit                  steady;
  int                  holds_asked;
  int                  config_writes;
  palette_scoreboard   sb;

  npcl_in_if  in_bus ();
  npcl_out_if out_bus ();

  nearest_palette_color_lookup_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("Timeout after %0t with %0d results outstanding", $time, sb.pending());
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready)
        sb.note_beat(mode_t'(in_bus.mode), in_bus.entry_index, in_bus.channel_0,
                     in_bus.channel_1, in_bus.channel_2);
      if (out_bus.valid && out_bus.ready)
        sb.check_result(out_bus.color_index, out_bus.min_distance);
    end
  end

  // The result side stalls at random unless steady is set, and holds off completely when asked.
  initial begin
    int hold_left;
    int holds_served;
    hold_left     = 0;
    holds_served  = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (holds_served < holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= steady || ($urandom_range(99) >= 23);
      end
    end
  end

  task automatic send_beat(mode_t m, logic [COLOR_W-1:0] slot, logic [CH_W-1:0] c0,
                           logic [CH_W-1:0] c1, logic [CH_W-1:0] c2);
    if (!steady) begin
      while ($urandom_range(99) < 23) begin
        in_bus.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_bus.valid       <= 1'b1;
    in_bus.mode        <= m;
    in_bus.entry_index <= slot;
    in_bus.channel_0   <= c0;
    in_bus.channel_1   <= c1;
    in_bus.channel_2   <= c2;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic load_entry(int slot, logic [23:0] rgb);
    send_beat(MODE_LOAD, slot[COLOR_W-1:0], rgb[23:16], rgb[15:8], rgb[7:0]);
  endtask

  task automatic map_pixel(logic [23:0] rgb);
    send_beat(MODE_MAP, COLOR_W'($urandom_range(255)), rgb[23:16], rgb[15:8], rgb[7:0]);
  endtask

  // Loads still walking down the row give no result, so the row is given time
  // to empty before the registers change.
  task automatic write_config(int colors, int channels);
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_COLOR_COUNT;
    cfg_wdata <= colors[COUNT_W-1:0];
    @(posedge clk);
    sb.write_reg(REG_COLOR_COUNT, colors[COUNT_W-1:0]);
    cfg_index <= REG_CHANNEL_COUNT;
    cfg_wdata <= {7'($urandom), channels[1:0]};
    @(posedge clk);
    sb.write_reg(REG_CHANNEL_COUNT, COUNT_W'(channels[1:0]));
    cfg_we <= 1'b0;
    config_writes++;
  endtask

  function automatic logic [7:0] random_channel();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return 8'h00;
    if (roll < 20) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic [23:0] random_color();
    int unsigned pick;
    if ($urandom_range(99) < 20) begin
      pick = $urandom_range(sb.active_entries() - 1);
      if (sb.written[pick])
        return {sb.pal[pick][0], sb.pal[pick][1], sb.pal[pick][2]};
    end
    return {random_channel(), random_channel(), random_channel()};
  endfunction

  task automatic run_phase(int beats);
    int slot;
    for (int i = 0; i < sb.active_entries(); i++)
      if (!sb.written[i]) load_entry(i, random_color());
    for (int n = 0; n < beats; n++) begin
      if ($urandom_range(99) < 30) begin
        if ($urandom_range(99) < 60) slot = $urandom_range(sb.active_entries() - 1);
        else slot = $urandom_range(SLOTS - 1);
        load_entry(slot, random_color());
      end else begin
        map_pixel(random_color());
      end
    end
  endtask

  initial begin
    sb                 = new();
    steady             = 1'b0;
    holds_asked        = 0;
    config_writes      = 0;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_COLOR_COUNT;
    cfg_wdata          <= '0;
    in_bus.valid       <= 1'b0;
    in_bus.mode        <= MODE_LOAD;
    in_bus.entry_index <= '0;
    in_bus.channel_0   <= '0;
    in_bus.channel_1   <= '0;
    in_bus.channel_2   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    write_config(4, 3);
    load_entry(0, 24'h000000);
    load_entry(1, 24'hFFFFFF);
    load_entry(2, 24'h00FF80);
    load_entry(3, 24'h000000);
    load_entry(255, 24'hFF00FF);
    map_pixel(24'h000000);
    map_pixel(24'hFFFFFF);
    map_pixel(24'hFF00FF);
    map_pixel(24'h808080);
    map_pixel(24'h01FE7F);
    map_pixel(24'hFF0000);
    map_pixel(24'h0000FF);
    load_entry(2, 24'h0A141E);
    map_pixel(24'h0A141E);
    load_entry(3, 24'h0A141E);
    map_pixel(24'h0B151F);

    // With no channel compared, every entry ties at zero.
    write_config(4, 0);
    map_pixel(24'hFFFFFF);
    map_pixel(24'h123456);

    // A count of zero searches entry 0 alone.
    write_config(0, 3);
    map_pixel(24'hFFFFFF);
    map_pixel(24'h000000);
    map_pixel(24'h7F7F7F);

    write_config(256, 3);
    run_phase(120);

    steady = 1'b1;
    write_config(511, 2);
    run_phase(80);
    steady = 1'b0;

    write_config($urandom_range(2, 40), 1);
    holds_asked++;
    run_phase(300);

    write_config($urandom_range(1, 256), 3);
    run_phase(80);

    write_config($urandom_range(257, 511), 0);
    run_phase(40);

    write_config(1, 3);
    run_phase(40);

    write_config($urandom_range(1, 511), $urandom_range(1, 3));
    run_phase(60);

    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d palette loads and %0d pixel lookups over %0d register settings.",
             sb.loads_seen, sb.maps_seen, config_writes);
    $display("Checked %0d lookup results, %0d mismatched.", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
